/* hdl/mmcv_pkg.sv */
// Shared types and method codes for the multi-method packet check verifier.
package mmcv_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	typedef enum logic [2:0] {
		METHOD_NONE     = 3'd0,
		METHOD_PARITY   = 3'd1,
		METHOD_XOR      = 3'd2,
		METHOD_CRC16    = 3'd3,
		METHOD_HAMMING  = 3'd4,
		METHOD_CHECKSUM = 3'd5
	} method_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [2:0]  opcode;
		logic [15:0] received_check;
		logic        last_byte;
	} item_t;

	typedef struct packed {
		logic [15:0] computed_check;
		logic        check_match;
	} result_t;

endpackage

/* hdl/mmcv_accum.sv */
// Per-packet check accumulators and selection of the reported check value.
module mmcv_accum (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  mmcv_pkg::item_t beat,
	output mmcv_pkg::result_t result
);
	import mmcv_pkg::*;

	logic [15:0] crc_q;
	logic [7:0]  sum_q;
	logic [7:0]  xor_q;
	logic        parity_q;
	logic [2:0]  ham_q;
	logic [2:0]  method_q;
	logic        first_q;

	logic [15:0] crc_base, crc_next;
	logic [7:0]  sum_base, sum_next;
	logic [7:0]  xor_base, xor_next;
	logic        parity_base, parity_next;
	logic [2:0]  ham_cur, method_cur;
	logic [7:0]  crc_x;
	logic [15:0] value;
	logic [7:0]  d;

	// A pending first byte starts from the cleared values and latches method and Hamming bits.
	always_comb begin
		d           = beat.data_byte;
		crc_base    = first_q ? CRC_INIT : crc_q;
		sum_base    = first_q ? 8'd0 : sum_q;
		xor_base    = first_q ? 8'd0 : xor_q;
		parity_base = first_q ? 1'b0 : parity_q;
		method_cur  = first_q ? beat.opcode : method_q;
		ham_cur     = first_q ? {d[1] ^ d[2] ^ d[3], d[0] ^ d[2] ^ d[3], d[0] ^ d[1] ^ d[3]}
		                      : ham_q;

		// Byte-wise CCITT CRC, polynomial 0x1021.
		crc_x       = crc_base[15:8] ^ d;
		crc_x       = crc_x ^ {4'd0, crc_x[7:4]};
		crc_next    = {crc_base[7:0], 8'd0} ^ {crc_x[3:0], 12'd0} ^ {3'd0, crc_x, 5'd0}
		              ^ {8'd0, crc_x};
		sum_next    = sum_base + d;
		xor_next    = xor_base ^ d;
		parity_next = parity_base ^ (^d);
	end

	always_comb begin
		case (method_cur)
			METHOD_PARITY:   value = {15'd0, parity_next};
			METHOD_XOR:      value = {8'd0, xor_next};
			METHOD_CRC16:    value = crc_next;
			METHOD_HAMMING:  value = {13'd0, ham_cur};
			METHOD_CHECKSUM: value = {8'd0, sum_next};
			default:         value = 16'd0;
		endcase
		result.computed_check = value;
		result.check_match    = (value == beat.received_check);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= CRC_INIT;
			sum_q    <= 8'd0;
			xor_q    <= 8'd0;
			parity_q <= 1'b0;
			ham_q    <= 3'd0;
			method_q <= METHOD_NONE;
			first_q  <= 1'b1;
		end else if (advance) begin
			if (beat.last_byte) begin
				crc_q    <= CRC_INIT;
				sum_q    <= 8'd0;
				xor_q    <= 8'd0;
				parity_q <= 1'b0;
				ham_q    <= 3'd0;
				method_q <= METHOD_NONE;
				first_q  <= 1'b1;
			end else begin
				crc_q    <= crc_next;
				sum_q    <= sum_next;
				xor_q    <= xor_next;
				parity_q <= parity_next;
				ham_q    <= ham_cur;
				method_q <= method_cur;
				first_q  <= 1'b0;
			end
		end
	end

endmodule

/* hdl/multi_method_check_verifier.sv */
// A final byte's result beat passes through the input register and then the result register.
// Throughput: one byte beat per cycle; the accumulator update is one short XOR/add step.
// Only a final byte waiting while the held result beat is stalled stops the input.
// Reset (arst_n low, asynchronous) empties both registers and restores the CRC to 0xFFFF,
// clears the other accumulators, and marks the next byte as the start of a packet.
module multi_method_check_verifier (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  mmcv_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output mmcv_pkg::result_t result
);
	import mmcv_pkg::*;

	// Input register: holds one byte beat until the accumulators take it.
	item_t   item_s1;
	logic    valid_s1;
	logic    blocked;
	logic    advance;
	result_t next_result;

	// A non-final byte never produces a result, so it moves on even when the
	// output beat is stalled. A final byte needs the output register free.
	assign blocked    = item_s1.last_byte && result_valid && result_stall;
	assign advance    = valid_s1 && !blocked;
	assign item_stall = valid_s1 && blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	mmcv_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.beat   (item_s1),
		.result (next_result)
	);

	// Result register: loads on a final byte, otherwise drains when the
	// receiver takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			result <= next_result;
		end
	end

endmodule

/* hdl/mmcv_checker.sv */
// Port-level checks for the multi-method packet check verifier, bound to the top level.
module mmcv_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input mmcv_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input mmcv_pkg::result_t result
);
	import mmcv_pkg::*;

	// The input is held back only by a stalled result beat.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("input stalled without output back pressure");

	// A stalled result beat stays and keeps its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result beat changed");

	// An accepted final byte with no back pressure next cycle yields a result beat.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.last_byte) ##1 !(result_valid && result_stall)
		|=> result_valid)
		else $error("final byte produced no result beat");

endmodule

bind multi_method_check_verifier mmcv_checker u_mmcv_checker (.*);
